// ===== design/backfill_job_scheduler_defines.svh =====
// assertion macros for the backfill job scheduler
// used by design files that carry concurrent assertions, no other dependencies
`ifndef BACKFILL_JOB_SCHEDULER_DEFINES_SVH
`define BACKFILL_JOB_SCHEDULER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bfs_pkg.sv =====
// shared widths, codes and record types of the backfill job scheduler
// no dependencies
`timescale 1ns / 1ps

package bfs_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int CLASS_COUNT_DEF = 8;

	localparam int ACT_W   = 3;
	localparam int CLS_W   = 3;
	localparam int SIZE_W  = 12;
	localparam int ID_W    = 32;
	localparam int HOLD_W  = 31;
	localparam int TIME_W  = 32;
	localparam int STAT_W  = 2;
	localparam int WAITO_W = 6;
	localparam int VIOL_W  = 16;

	localparam logic [SIZE_W-1:0] SIZE_MAX      = '1;
	localparam logic [VIOL_W-1:0] VIOL_MAX      = '1;
	localparam logic [SIZE_W-1:0] SERVERS_RESET = 12'd64;

	localparam logic [ACT_W-1:0] ACT_ARRIVAL = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DEPART  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SHIFT   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FIT     = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_QFULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_TFULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_TEMPTY = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   jid;
		logic [CLS_W-1:0]  jcls;
		logic [SIZE_W-1:0] jsize;
		logic [HOLD_W-1:0] jhold;
	} q_entry_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] ctime;
		logic [SIZE_W-1:0]        csize;
	} t_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]   jid;
		logic [CLS_W-1:0]  jcls;
		logic [SIZE_W-1:0] jsize;
	} s_entry_t;

	// per-class counter update, one class per cycle
	typedef struct packed {
		logic [CLS_W-1:0] idx;
		logic             wait_inc;
		logic             wait_dec;
		logic             serv_inc;
		logic             serv_dec;
	} cls_op_t;

endpackage

// ===== design/bfs_req_if.sv =====
// request channel of the backfill job scheduler
// depends on bfs_pkg
`timescale 1ns / 1ps

interface bfs_req_if;
	logic                                valid;
	logic                                ready;
	logic [bfs_pkg::ACT_W-1:0]           action;
	logic [bfs_pkg::CLS_W-1:0]           job_class;
	logic [bfs_pkg::SIZE_W-1:0]          job_size;
	logic [bfs_pkg::ID_W-1:0]            job_id;
	logic [bfs_pkg::HOLD_W-1:0]          hold_time;
	logic signed [bfs_pkg::TIME_W-1:0]   time_value;

	modport source (
		output valid, action, job_class, job_size, job_id, hold_time, time_value,
		input  ready
	);
	modport sink (
		input  valid, action, job_class, job_size, job_id, hold_time, time_value,
		output ready
	);
endinterface

// ===== design/bfs_rsp_if.sv =====
// result channel of the backfill job scheduler
// depends on bfs_pkg
`timescale 1ns / 1ps

interface bfs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         started;
	logic [bfs_pkg::ID_W-1:0]     start_id;
	logic [bfs_pkg::CLS_W-1:0]    start_class;
	logic [bfs_pkg::SIZE_W-1:0]   start_size;
	logic                         last;
	logic [bfs_pkg::SIZE_W-1:0]   free_now;
	logic                         fit_added;
	logic [bfs_pkg::STAT_W-1:0]   status;
	logic [bfs_pkg::WAITO_W-1:0]  class_waiting;
	logic [bfs_pkg::SIZE_W-1:0]   class_serving;
	logic [bfs_pkg::VIOL_W-1:0]   violations;

	modport source (
		output valid, started, start_id, start_class, start_size, last, free_now,
			fit_added, status, class_waiting, class_serving, violations,
		input  ready
	);
	modport sink (
		input  valid, started, start_id, start_class, start_size, last, free_now,
			fit_added, status, class_waiting, class_serving, violations,
		output ready
	);
endinterface

// ===== design/backfill_job_scheduler.sv =====
// Backfill job scheduler: FIFO wait queue, time-sorted completion table, backfill fit.
// Requests come in on req (valid/ready), results leave on rsp (valid/ready); every
// accepted request yields one result per job it starts, in start order, then a
// closing result with last set. free_now, class counts, status and violations are
// the values after the whole request, so results are sent only once it has finished.
// cfg_we/cfg_wdata load free servers, but only when nothing waits and nothing runs;
// other writes are dropped. Write only between requests.
// Wait queue, completion table and start list are RAMs with one write port and one
// registered read port; each pass reads one entry, then evaluates and writes it back.
// A request may walk the table (departure, insert, shift, fit scan) and the queue
// (arrival, departure, fit), then sends one result per started job and a closing one.
// One request is worked at a time; req.ready is high only when idle and the closing
// result has been taken, since the status fields come straight from state.
// A stall on rsp holds the block in place: nothing new is taken until it clears.
// Reset clears queue and table counts, class counters and violations and sets free
// servers to 64; no memory sweep is needed, entries are read only below their counts.
`timescale 1ns / 1ps
`include "backfill_job_scheduler_defines.svh"

module backfill_job_scheduler #(
	parameter int QUEUE_DEPTH = bfs_pkg::QUEUE_DEPTH_DEF,
	parameter int TABLE_DEPTH = bfs_pkg::TABLE_DEPTH_DEF,
	parameter int CLASS_COUNT = bfs_pkg::CLASS_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bfs_req_if.sink                       req,
	bfs_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [bfs_pkg::SIZE_W-1:0]    cfg_wdata
);

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int TAW = $clog2(TABLE_DEPTH);
	localparam int TCW = $clog2(TABLE_DEPTH + 1);
	localparam int ACW = bfs_pkg::SIZE_W + TCW + 1;
	localparam int SW  = bfs_pkg::SIZE_W;
	localparam int TW  = bfs_pkg::TIME_W;

	typedef enum logic [3:0] {
		S_IDLE, S_TRD, S_TEV, S_HRD, S_HEV, S_QRD, S_QEV, S_ERD, S_EWR, S_ECL
	} state_t;

	typedef enum logic [1:0] {T_DEP, T_INS, T_SHF, T_FSC} tmode_t;

	// memories
	bfs_pkg::q_entry_t queue_mem_q [QUEUE_DEPTH];
	bfs_pkg::t_entry_t table_mem_q [TABLE_DEPTH];
	bfs_pkg::s_entry_t start_mem_q [QUEUE_DEPTH];
	bfs_pkg::q_entry_t q_rdata_q;
	bfs_pkg::t_entry_t t_rdata_q;
	bfs_pkg::s_entry_t s_rdata_q;

	logic              q_we;
	logic [QAW-1:0]    q_waddr;
	bfs_pkg::q_entry_t q_wdata;
	logic              t_we;
	logic [TAW-1:0]    t_waddr;
	bfs_pkg::t_entry_t t_wdata;

	// control and latched request
	state_t                        state_q;
	tmode_t                        tmode_q;
	logic [QCW-1:0]                q_count_q, qr_q, qw_q, st_n_q, er_q;
	logic [TCW-1:0]                t_count_q, tr_q, tw_q;
	logic [SW-1:0]                 free_q;
	logic [bfs_pkg::VIOL_W-1:0]    viol_q;
	logic [bfs_pkg::CLS_W-1:0]     cls_q;
	logic [SW-1:0]                 size_q, hsize_q;
	logic signed [TW-1:0]          tv_q, last_q, resv_q;
	logic [bfs_pkg::STAT_W-1:0]    status_q;
	logic                          added_q, head_q, fit_q, ins_q;
	bfs_pkg::t_entry_t             carry_q;
	logic [ACW-1:0]                acc_q;

	// output register
	logic                          rsp_valid_q, rsp_started_q, rsp_last_q;
	logic [bfs_pkg::ID_W-1:0]      rsp_id_q;
	logic [bfs_pkg::CLS_W-1:0]     rsp_cls_q;
	logic [SW-1:0]                 rsp_size_q;

	// class counters
	bfs_pkg::cls_op_t              cls_op;
	logic [QCW-1:0]                cls_waiting;
	logic [SW-1:0]                 cls_serving;
	logic                          any_serving;

	logic                          accept, slot_free, rsp_load, q_full, t_full;
	logic                          q_fits, q_ends, q_start, t_merge, t_cover;
	logic signed [TW:0]            sdiff;
	logic signed [TW-1:0]          nt;
	logic signed [TW+1:0]          end_t;
	logic [ACW-1:0]                acc_next;
	logic [SW:0]                   free_sum;
	logic [TCW-1:0]                tr_m1, tw_m1;
	bfs_pkg::q_entry_t             new_q;
	bfs_pkg::t_entry_t             new_t;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rsp_load  = (state_q == S_EWR || state_q == S_ECL) && slot_free;
	assign q_full    = (q_count_q == QCW'(QUEUE_DEPTH));
	assign t_full    = (t_count_q == TCW'(TABLE_DEPTH));
	assign tr_m1     = tr_q - TCW'(1);
	assign tw_m1     = tw_q - TCW'(1);
	assign free_sum  = {1'b0, free_q} + {1'b0, req.job_size};

	assign new_q = '{jid: req.job_id, jcls: req.job_class, jsize: req.job_size,
		jhold: req.hold_time};
	assign new_t = '{ctime: tv_q, csize: size_q};

	// shift with saturation to the signed 32-bit range
	assign sdiff = {t_rdata_q.ctime[TW-1], t_rdata_q.ctime} - {tv_q[TW-1], tv_q};
	always_comb begin
		if (sdiff[TW] != sdiff[TW-1]) begin
			nt = sdiff[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
		end else begin
			nt = sdiff[TW-1:0];
		end
	end
	assign t_merge = (tw_q != '0) && (last_q == nt);

	// cumulative release scan for the reservation
	assign acc_next = acc_q + ACW'(t_rdata_q.csize);
	assign t_cover  = acc_next >= ACW'(hsize_q);

	// queue pass start decision
	assign end_t  = $signed({3'b000, q_rdata_q.jhold}) + $signed({{2{tv_q[TW-1]}}, tv_q});
	assign q_fits = (free_q != '0) && (q_rdata_q.jsize <= free_q);
	assign q_ends = end_t <= $signed({{2{resv_q[TW-1]}}, resv_q});
	assign q_start = q_fits && (fit_q ? q_ends : head_q);

	always_comb begin
		q_we    = 1'b0;
		q_waddr = qw_q[QAW-1:0];
		q_wdata = q_rdata_q;
		t_we    = 1'b0;
		t_waddr = tr_q[TAW-1:0];
		t_wdata = t_rdata_q;
		cls_op  = '{idx: cls_q, wait_inc: 1'b0, wait_dec: 1'b0, serv_inc: 1'b0,
			serv_dec: 1'b0};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cls_op.idx = req.job_class;
				end
				if (accept && req.action == bfs_pkg::ACT_ARRIVAL && !q_full) begin
					q_we            = 1'b1;
					q_waddr         = q_count_q[QAW-1:0];
					q_wdata         = new_q;
					cls_op.wait_inc = 1'b1;
				end
				if (accept && req.action == bfs_pkg::ACT_DEPART) begin
					cls_op.serv_dec = 1'b1;
				end
			end
			S_TRD: begin
				// insertion falls past the last entry
				if (tmode_q == T_INS && tr_q == t_count_q && (ins_q || !t_full)) begin
					t_we    = 1'b1;
					t_wdata = ins_q ? carry_q : new_t;
				end
			end
			S_TEV: begin
				case (tmode_q)
					T_DEP: begin
						t_we    = 1'b1;
						t_waddr = tr_m1[TAW-1:0];
					end
					T_INS: begin
						if (ins_q) begin
							t_we    = 1'b1;
							t_wdata = carry_q;
						end else if (t_rdata_q.ctime == tv_q) begin
							t_we    = 1'b1;
							t_wdata = '{ctime: tv_q, csize: size_q};
						end else if (t_rdata_q.ctime > tv_q && !t_full) begin
							t_we    = 1'b1;
							t_wdata = new_t;
						end
					end
					T_SHF: begin
						t_we    = 1'b1;
						t_waddr = t_merge ? tw_m1[TAW-1:0] : tw_q[TAW-1:0];
						t_wdata = '{ctime: nt, csize: t_rdata_q.csize};
					end
					default: begin
					end
				endcase
			end
			S_QEV: begin
				cls_op.idx = q_rdata_q.jcls;
				if (q_start) begin
					cls_op.wait_dec = 1'b1;
					cls_op.serv_inc = 1'b1;
				end else begin
					q_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem_q[q_waddr] <= q_wdata;
		end
		q_rdata_q <= queue_mem_q[qr_q[QAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			table_mem_q[t_waddr] <= t_wdata;
		end
		t_rdata_q <= table_mem_q[tr_q[TAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_QEV && q_start) begin
			start_mem_q[st_n_q[QAW-1:0]] <= '{jid: q_rdata_q.jid, jcls: q_rdata_q.jcls,
				jsize: q_rdata_q.jsize};
		end
		s_rdata_q <= start_mem_q[er_q[QAW-1:0]];
	end

	bfs_class_ctrs #(
		.CLASS_COUNT (CLASS_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_class_ctrs (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (cls_op),
		.waiting     (cls_waiting),
		.serving     (cls_serving),
		.any_serving (any_serving)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tmode_q       <= T_DEP;
			q_count_q     <= '0;
			qr_q          <= '0;
			qw_q          <= '0;
			st_n_q        <= '0;
			er_q          <= '0;
			t_count_q     <= '0;
			tr_q          <= '0;
			tw_q          <= '0;
			free_q        <= bfs_pkg::SERVERS_RESET;
			viol_q        <= '0;
			cls_q         <= '0;
			size_q        <= '0;
			hsize_q       <= '0;
			tv_q          <= '0;
			last_q        <= '0;
			resv_q        <= '0;
			status_q      <= bfs_pkg::ST_OK;
			added_q       <= 1'b0;
			head_q        <= 1'b0;
			fit_q         <= 1'b0;
			ins_q         <= 1'b0;
			carry_q       <= '0;
			acc_q         <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_started_q <= 1'b0;
			rsp_last_q    <= 1'b0;
			rsp_id_q      <= '0;
			rsp_cls_q     <= '0;
			rsp_size_q    <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cls_q    <= req.job_class;
						size_q   <= req.job_size;
						tv_q     <= req.time_value;
						added_q  <= 1'b0;
						st_n_q   <= '0;
						er_q     <= '0;
						qr_q     <= '0;
						qw_q     <= '0;
						head_q   <= 1'b1;
						fit_q    <= 1'b0;
						ins_q    <= 1'b0;
						tr_q     <= '0;
						tw_q     <= '0;
						case (req.action)
							bfs_pkg::ACT_ARRIVAL: begin
								if (q_full) begin
									status_q <= bfs_pkg::ST_QFULL;
								end else begin
									status_q  <= bfs_pkg::ST_OK;
									q_count_q <= q_count_q + QCW'(1);
								end
								state_q <= S_QRD;
							end
							bfs_pkg::ACT_DEPART: begin
								free_q <= free_sum[SW] ? bfs_pkg::SIZE_MAX : free_sum[SW-1:0];
								if (t_count_q == '0) begin
									status_q <= bfs_pkg::ST_TEMPTY;
									if (viol_q != bfs_pkg::VIOL_MAX) begin
										viol_q <= viol_q + bfs_pkg::VIOL_W'(1);
									end
									state_q <= S_QRD;
								end else begin
									// entry 0 drops out, the rest move down one place
									status_q <= bfs_pkg::ST_OK;
									tmode_q  <= T_DEP;
									tr_q     <= TCW'(1);
									state_q  <= S_TRD;
								end
							end
							bfs_pkg::ACT_INSERT: begin
								status_q <= bfs_pkg::ST_OK;
								tmode_q  <= T_INS;
								state_q  <= S_TRD;
							end
							bfs_pkg::ACT_SHIFT: begin
								status_q <= bfs_pkg::ST_OK;
								tmode_q  <= T_SHF;
								state_q  <= S_TRD;
							end
							bfs_pkg::ACT_FIT: begin
								status_q <= bfs_pkg::ST_OK;
								state_q  <= (q_count_q == '0) ? S_ERD : S_HRD;
							end
							default: begin
								status_q <= bfs_pkg::ST_OK;
								state_q  <= S_ERD;
							end
						endcase
					end else if (cfg_we && q_count_q == '0 && !any_serving) begin
						free_q <= cfg_wdata;
					end
				end
				S_TRD: begin
					if (tr_q == t_count_q) begin
						case (tmode_q)
							T_DEP: begin
								t_count_q <= t_count_q - TCW'(1);
								state_q   <= S_QRD;
							end
							T_INS: begin
								if (ins_q || !t_full) begin
									t_count_q <= t_count_q + TCW'(1);
								end else begin
									status_q <= bfs_pkg::ST_TFULL;
								end
								state_q <= S_ERD;
							end
							T_SHF: begin
								t_count_q <= tw_q;
								state_q   <= S_ERD;
							end
							default: begin
								// no entry covers the head job
								state_q <= S_ERD;
							end
						endcase
					end else begin
						state_q <= S_TEV;
					end
				end
				S_TEV: begin
					tr_q <= tr_q + TCW'(1);
					case (tmode_q)
						T_INS: begin
							if (ins_q) begin
								carry_q <= t_rdata_q;
								state_q <= S_TRD;
							end else if (t_rdata_q.ctime == tv_q) begin
								state_q <= S_ERD;
							end else if (t_rdata_q.ctime > tv_q) begin
								if (t_full) begin
									status_q <= bfs_pkg::ST_TFULL;
									state_q  <= S_ERD;
								end else begin
									carry_q <= t_rdata_q;
									ins_q   <= 1'b1;
									state_q <= S_TRD;
								end
							end else begin
								state_q <= S_TRD;
							end
						end
						T_SHF: begin
							last_q  <= nt;
							state_q <= S_TRD;
							if (!t_merge) begin
								tw_q <= tw_q + TCW'(1);
							end
						end
						T_FSC: begin
							acc_q <= acc_next;
							if (t_cover) begin
								resv_q <= t_rdata_q.ctime;
								fit_q  <= 1'b1;
								state_q <= (t_rdata_q.ctime <= 0) ? S_ERD : S_QRD;
							end else begin
								state_q <= S_TRD;
							end
						end
						default: begin
							state_q <= S_TRD;
						end
					endcase
				end
				S_HRD: begin
					state_q <= S_HEV;
				end
				S_HEV: begin
					hsize_q <= q_rdata_q.jsize;
					acc_q   <= ACW'(free_q);
					tmode_q <= T_FSC;
					state_q <= S_TRD;
				end
				S_QRD: begin
					if (qr_q == q_count_q) begin
						q_count_q <= qw_q;
						state_q   <= S_ERD;
					end else begin
						state_q <= S_QEV;
					end
				end
				S_QEV: begin
					if (q_start) begin
						st_n_q <= st_n_q + QCW'(1);
						free_q <= free_q - q_rdata_q.jsize;
						if (fit_q) begin
							added_q <= 1'b1;
						end
					end else begin
						qw_q   <= qw_q + QCW'(1);
						head_q <= 1'b0;
					end
					qr_q    <= qr_q + QCW'(1);
					state_q <= S_QRD;
				end
				S_ERD: begin
					state_q <= (er_q == st_n_q) ? S_ECL : S_EWR;
				end
				S_EWR: begin
					if (slot_free) begin
						rsp_started_q <= 1'b1;
						rsp_last_q    <= 1'b0;
						rsp_id_q      <= s_rdata_q.jid;
						rsp_cls_q     <= s_rdata_q.jcls;
						rsp_size_q    <= s_rdata_q.jsize;
						er_q          <= er_q + QCW'(1);
						state_q       <= S_ERD;
					end
				end
				S_ECL: begin
					if (slot_free) begin
						rsp_started_q <= 1'b0;
						rsp_last_q    <= 1'b1;
						rsp_id_q      <= '0;
						rsp_cls_q     <= '0;
						rsp_size_q    <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// status fields are final once results are sent, so they come straight from state
	assign rsp.valid         = rsp_valid_q;
	assign rsp.started       = rsp_started_q;
	assign rsp.start_id      = rsp_id_q;
	assign rsp.start_class   = rsp_cls_q;
	assign rsp.start_size    = rsp_size_q;
	assign rsp.last          = rsp_last_q;
	assign rsp.free_now      = free_q;
	assign rsp.fit_added     = added_q;
	assign rsp.status        = status_q;
	assign rsp.class_waiting = bfs_pkg::WAITO_W'(cls_waiting);
	assign rsp.class_serving = cls_serving;
	assign rsp.violations    = viol_q;

	`BFS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready,
		"request accepted while another is in progress")
	`BFS_ASSERT_SAME(a_start_room, clk, arst_n, state_q == S_QEV && q_start,
		st_n_q < QCW'(QUEUE_DEPTH), "start list overflow")
	`BFS_ASSERT_SAME(a_compact_order, clk, arst_n, state_q == S_QEV && q_we,
		qw_q <= qr_q, "queue compaction overtook its read pointer")
	`BFS_ASSERT_NEXT(a_closing_sent, clk, arst_n, state_q == S_ECL && slot_free,
		rsp.valid && rsp.last && !rsp.started, "closing result not presented")

endmodule

// ===== design/bfs_class_ctrs.sv =====
// per-class waiting and running job counters, one update and one read per cycle
// depends on bfs_pkg
`timescale 1ns / 1ps

module bfs_class_ctrs #(
	parameter int CLASS_COUNT = bfs_pkg::CLASS_COUNT_DEF,
	parameter int QUEUE_DEPTH = bfs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bfs_pkg::cls_op_t                    op,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]    waiting,
	output logic [bfs_pkg::SIZE_W-1:0]          serving,
	output logic                                any_serving
);

	localparam int WAIT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CIW    = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;

	logic [WAIT_W-1:0]          wait_q [CLASS_COUNT];
	logic [bfs_pkg::SIZE_W-1:0] serv_q [CLASS_COUNT];
	logic                       known;
	logic [CIW-1:0]             idx;

	assign known   = int'(op.idx) < CLASS_COUNT;
	assign idx     = CIW'(op.idx);
	assign waiting = known ? wait_q[idx] : '0;
	assign serving = known ? serv_q[idx] : '0;

	always_comb begin
		any_serving = 1'b0;
		for (int c = 0; c < CLASS_COUNT; c++) begin
			any_serving = any_serving | (serv_q[c] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				wait_q[c] <= '0;
				serv_q[c] <= '0;
			end
		end else if (known) begin
			if (op.wait_inc) begin
				wait_q[idx] <= wait_q[idx] + WAIT_W'(1);
			end else if (op.wait_dec && wait_q[idx] != '0) begin
				wait_q[idx] <= wait_q[idx] - WAIT_W'(1);
			end
			if (op.serv_inc && serv_q[idx] != bfs_pkg::SIZE_MAX) begin
				serv_q[idx] <= serv_q[idx] + bfs_pkg::SIZE_W'(1);
			end else if (op.serv_dec && serv_q[idx] != '0) begin
				serv_q[idx] <= serv_q[idx] - bfs_pkg::SIZE_W'(1);
			end
		end
	end

endmodule

// ===== tb/schedule_checker.sv =====
// watches the request and result channels of the backfill job scheduler, predicts every
// result from its own copy of the queue, completion table and counters, and compares
// depends on bfs_pkg, bfs_req_if, bfs_rsp_if
`timescale 1ns / 1ps

module schedule_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	bfs_req_if                         req,
	bfs_rsp_if                         rsp,
	input  logic                       cfg_we,
	input  logic [bfs_pkg::SIZE_W-1:0] cfg_wdata,
	output int                         mismatches,
	output int                         outstanding
);
	import bfs_pkg::*;

	localparam int QD = QUEUE_DEPTH_DEF;
	localparam int TD = TABLE_DEPTH_DEF;
	localparam int CC = CLASS_COUNT_DEF;

	typedef struct {
		bit                started;
		bit [ID_W-1:0]     start_id;
		bit [CLS_W-1:0]    start_class;
		bit [SIZE_W-1:0]   start_size;
		bit                last;
		bit [SIZE_W-1:0]   free_now;
		bit                fit_added;
		bit [STAT_W-1:0]   status;
		bit [WAITO_W-1:0]  class_waiting;
		bit [SIZE_W-1:0]   class_serving;
		bit [VIOL_W-1:0]   violations;
	} outcome_t;

	outcome_t  scheduled_outcomes[$];
	s_entry_t  launched[$];

	// predicted scheduler state
	int unsigned    total_servers;
	int unsigned    free_servers;
	bit [ID_W-1:0]  wait_id[QD];
	int unsigned    wait_cls[QD];
	int unsigned    wait_size[QD];
	longint         wait_hold[QD];
	int unsigned    wait_count;
	longint         done_time[TD];
	int unsigned    done_size[TD];
	int unsigned    done_count;
	int unsigned    waiting_of[CC];
	int unsigned    serving_of[CC];
	int unsigned    violation_total;

	function automatic void clear_state();
		total_servers = SERVERS_RESET;
		free_servers = SERVERS_RESET;
		wait_count = 0;
		done_count = 0;
		violation_total = 0;
		foreach (waiting_of[c]) begin
			waiting_of[c] = 0;
			serving_of[c] = 0;
		end
		scheduled_outcomes.delete();
	endfunction

	function automatic void load_servers(int unsigned v);
		bit idle;
		idle = (wait_count == 0);
		total_servers = v;
		foreach (serving_of[c])
			if (serving_of[c] != 0) idle = 0;
		if (idle) free_servers = v;
	endfunction

	function automatic void launch_job(int unsigned i);
		s_entry_t s;
		int unsigned c;
		c = wait_cls[i];
		s.jid = wait_id[i];
		s.jcls = c;
		s.jsize = wait_size[i];
		launched = {launched, s};
		free_servers -= wait_size[i];
		if (c < CC) begin
			if (serving_of[c] < SIZE_MAX) serving_of[c]++;
			if (waiting_of[c] > 0) waiting_of[c]--;
		end
		for (int unsigned k = i; k + 1 < wait_count; k++) begin
			wait_id[k] = wait_id[k+1];
			wait_cls[k] = wait_cls[k+1];
			wait_size[k] = wait_size[k+1];
			wait_hold[k] = wait_hold[k+1];
		end
		wait_count--;
	endfunction

	function automatic void start_from_head();
		while (free_servers > 0 && wait_count > 0 && wait_size[0] <= free_servers)
			launch_job(0);
	endfunction

	function automatic bit backfill(longint now);
		bit added;
		longint resv;
		longint acc;
		int unsigned i;
		added = 0;
		resv = -1;
		if (wait_count == 0) return 0;
		acc = free_servers;
		for (int unsigned k = 0; k < done_count; k++) begin
			acc += done_size[k];
			if (acc >= wait_size[0]) begin
				resv = done_time[k];
				break;
			end
		end
		if (resv <= 0) return 0;
		i = 0;
		while (i < wait_count) begin
			if (free_servers == 0) break;
			if (wait_size[i] <= free_servers && wait_hold[i] + now <= resv) begin
				launch_job(i);
				added = 1;
			end else begin
				i++;
			end
		end
		return added;
	endfunction

	function automatic bit [STAT_W-1:0] add_completion(longint t, int unsigned sz);
		int unsigned p;
		p = 0;
		while (p < done_count && done_time[p] < t) p++;
		if (p < done_count && done_time[p] == t) begin
			done_size[p] = sz;
			return ST_OK;
		end
		if (done_count >= TD) return ST_TFULL;
		for (int unsigned k = done_count; k > p; k--) begin
			done_time[k] = done_time[k-1];
			done_size[k] = done_size[k-1];
		end
		done_time[p] = t;
		done_size[p] = sz;
		done_count++;
		return ST_OK;
	endfunction

	function automatic void shift_completions(longint s);
		int unsigned w;
		longint nt;
		w = 0;
		for (int unsigned i = 0; i < done_count; i++) begin
			nt = done_time[i] - s;
			if (nt > 64'sd2147483647) nt = 64'sd2147483647;
			if (nt < -64'sd2147483648) nt = -64'sd2147483648;
			// entries landing on the same time merge, later size wins
			if (w > 0 && done_time[w-1] == nt) begin
				done_size[w-1] = done_size[i];
			end else begin
				done_time[w] = nt;
				done_size[w] = done_size[i];
				w++;
			end
		end
		done_count = w;
	endfunction

	function automatic void schedule_step(bit [ACT_W-1:0] act, bit [CLS_W-1:0] cls,
			bit [SIZE_W-1:0] sz, bit [ID_W-1:0] id, bit [HOLD_W-1:0] hold,
			bit signed [TIME_W-1:0] tv);
		bit [STAT_W-1:0] st;
		bit added;
		outcome_t o;
		int unsigned n;
		st = ST_OK;
		added = 0;
		launched.delete();
		case (act)
			ACT_ARRIVAL: begin
				if (wait_count >= QD) begin
					st = ST_QFULL;
				end else begin
					wait_id[wait_count] = id;
					wait_cls[wait_count] = cls;
					wait_size[wait_count] = sz;
					wait_hold[wait_count] = hold;
					wait_count++;
					if (cls < CC) waiting_of[cls]++;
				end
				start_from_head();
			end
			ACT_DEPART: begin
				if (cls < CC && serving_of[cls] > 0) serving_of[cls]--;
				free_servers += sz;
				if (free_servers > SIZE_MAX) free_servers = SIZE_MAX;
				if (done_count > 0) begin
					for (int unsigned k = 0; k + 1 < done_count; k++) begin
						done_time[k] = done_time[k+1];
						done_size[k] = done_size[k+1];
					end
					done_count--;
				end else begin
					st = ST_TEMPTY;
					if (violation_total < VIOL_MAX) violation_total++;
				end
				start_from_head();
			end
			ACT_INSERT: st = add_completion(tv, sz);
			ACT_SHIFT:  shift_completions(tv);
			ACT_FIT:    added = backfill(tv);
			default: ;
		endcase
		n = launched.size();
		for (int unsigned k = 0; k <= n; k++) begin
			o.started = (k < n);
			o.start_id = (k < n) ? launched[k].jid : '0;
			o.start_class = (k < n) ? launched[k].jcls : '0;
			o.start_size = (k < n) ? launched[k].jsize : '0;
			o.last = (k == n);
			o.free_now = free_servers;
			o.fit_added = added;
			o.status = st;
			o.class_waiting = (cls < CC) ? waiting_of[cls] : 0;
			o.class_serving = (cls < CC) ? serving_of[cls] : 0;
			o.violations = violation_total;
			scheduled_outcomes = {scheduled_outcomes, o};
		end
	endfunction

	function automatic void compare_field(string name, longint e, longint a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			mismatches++;
		end
	endfunction

	function automatic void check_result();
		outcome_t e;
		if (scheduled_outcomes.size() == 0) begin
			$error("result with no request pending");
			mismatches++;
			return;
		end
		e = scheduled_outcomes.pop_front();
		compare_field("started", e.started, rsp.started);
		compare_field("start_id", e.start_id, rsp.start_id);
		compare_field("start_class", e.start_class, rsp.start_class);
		compare_field("start_size", e.start_size, rsp.start_size);
		compare_field("last", e.last, rsp.last);
		compare_field("free_now", e.free_now, rsp.free_now);
		compare_field("fit_added", e.fit_added, rsp.fit_added);
		compare_field("status", e.status, rsp.status);
		compare_field("class_waiting", e.class_waiting, rsp.class_waiting);
		compare_field("class_serving", e.class_serving, rsp.class_serving);
		compare_field("violations", e.violations, rsp.violations);
	endfunction

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				check_result();
			if (cfg_we)
				load_servers(cfg_wdata);
			if (req.valid === 1'b1 && req.ready === 1'b1)
				schedule_step(req.action, req.job_class, req.job_size, req.job_id,
					req.hold_time, req.time_value);
		end
		outstanding = scheduled_outcomes.size();
	end

endmodule

// ===== tb/testbench.sv =====
// top of the backfill job scheduler testbench: clock, reset, request stimulus,
// result back-pressure and verdict; depends on bfs_pkg, both channel interfaces,
// schedule_checker and the scheduler itself
`timescale 1ns / 1ps

module testbench;
	import bfs_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEM_TARGET = 320;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;
	int mismatches;
	int outstanding;

	bfs_req_if req_ch();
	bfs_rsp_if rsp_ch();

	backfill_job_scheduler dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	schedule_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	bit calm;
	bit choke;
	int sent;
	int unsigned servers_now;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (choke) begin
				rsp_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				choke = 0;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	task automatic submit(bit [ACT_W-1:0] act, bit [CLS_W-1:0] cls, bit [SIZE_W-1:0] sz,
			bit [ID_W-1:0] id, bit [HOLD_W-1:0] hold, bit [TIME_W-1:0] tv);
		int g;
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.job_class <= cls;
		req_ch.job_size <= sz;
		req_ch.job_id <= id;
		req_ch.hold_time <= hold;
		req_ch.time_value <= tv;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sent++;
		g = pick_gap();
		if (g > 0) begin
			req_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_servers(bit [SIZE_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		servers_now = v;
	endtask

	task automatic random_event();
		int r;
		int unsigned lim;
		bit [SIZE_W-1:0] sz;
		r = $urandom_range(0, 99);
		lim = (servers_now < 16) ? servers_now + 1 : servers_now / 3;
		sz = ($urandom_range(0, 99) < 88) ? $urandom_range(0, lim) : $urandom_range(0, 4095);
		if (r < 35)
			submit(ACT_ARRIVAL, $urandom_range(0, 7), sz, $urandom,
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1500), 0);
		else if (r < 55)
			submit(ACT_DEPART, $urandom_range(0, 7), sz, $urandom, 0, 0);
		else if (r < 75)
			submit(ACT_INSERT, $urandom_range(0, 7), sz, 0, 0,
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2000));
		else if (r < 90)
			submit(ACT_FIT, $urandom_range(0, 7), 0, 0, 0,
				($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500));
		else if (r < 95)
			submit(ACT_SHIFT, $urandom_range(0, 7), 0, 0, 0,
				($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300));
		else
			submit($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		int p;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_ARRIVAL;
		req_ch.job_class <= '0;
		req_ch.job_size <= '0;
		req_ch.job_id <= '0;
		req_ch.hold_time <= '0;
		req_ch.time_value <= '0;
		calm = 0;
		choke = 0;
		sent = 0;
		servers_now = SERVERS_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-table departure, zero size, backfill window, extremes
		submit(ACT_DEPART, 3'd7, 12'd0, 0, 0, 0);
		submit(ACT_FIT, 3'd0, 12'd0, 0, 0, 32'd10);
		submit(ACT_ARRIVAL, 3'd0, 12'd0, 32'hffffffff, 31'h7fffffff, 0);
		set_servers(12'd8);
		submit(ACT_ARRIVAL, 3'd1, 12'd4, 32'd1, 31'd100, 0);
		submit(ACT_ARRIVAL, 3'd2, 12'd6, 32'd2, 31'd100, 0);
		submit(ACT_ARRIVAL, 3'd3, 12'd2, 32'd3, 31'd10, 0);
		submit(ACT_ARRIVAL, 3'd4, 12'd2, 32'd4, 31'd900, 0);
		submit(ACT_FIT, 3'd3, 12'd0, 0, 0, 32'd0);
		submit(ACT_INSERT, 3'd0, 12'd4, 0, 0, 32'd50);
		submit(ACT_INSERT, 3'd0, 12'd4, 0, 0, 32'd200);
		submit(ACT_INSERT, 3'd0, 12'd3, 0, 0, 32'd200);
		submit(ACT_FIT, 3'd3, 12'd0, 0, 0, 32'd0);
		submit(ACT_FIT, 3'd4, 12'd0, 0, 0, 32'd5);
		submit(ACT_INSERT, 3'd0, 12'd1, 0, 0, 32'h7fff0000);
		submit(ACT_INSERT, 3'd0, 12'd1, 0, 0, 32'h80000000);
		submit(ACT_SHIFT, 3'd0, 12'd0, 0, 0, 32'h80000001);
		submit(ACT_SHIFT, 3'd0, 12'd0, 0, 0, 32'h7fffffff);
		submit(ACT_DEPART, 3'd1, 12'hfff, 0, 0, 0);
		submit(ACT_DEPART, 3'd5, 12'd1, 0, 0, 0);
		submit(3'd5, 3'd2, 12'd1, 0, 0, 0);
		submit(3'd6, 3'd2, 12'd1, 0, 0, 0);
		submit(3'd7, 3'd7, 12'hfff, 32'hffffffff, 31'h7fffffff, 32'hffffffff);
		set_servers(12'd4095);

		p = 0;
		while (sent < ITEM_TARGET) begin
			case (p % 6)
				0: set_servers(12'd1);
				1: set_servers(12'd4095);
				2: set_servers($urandom_range(2, 16));
				3: set_servers($urandom);
				default: set_servers($urandom_range(16, 200));
			endcase
			calm = (p % 6 == 4);
			if (p % 6 == 2) choke = 1;
			// queue overflow: jobs that never fit on a single server
			if (p == 0)
				repeat (34) submit(ACT_ARRIVAL, $urandom, 12'd2, $urandom, $urandom, 0);
			// table overflow: distinct completion times
			if (p == 1)
				for (int k = 0; k < 66; k++)
					submit(ACT_INSERT, 3'd0, $urandom, 0, 0, k * 7 + 1);
			repeat (30) random_event();
			calm = 0;
			p++;
		end

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== backfill_job_scheduler.f =====
+incdir+design
design/bfs_pkg.sv
design/bfs_req_if.sv
design/bfs_rsp_if.sv
design/bfs_class_ctrs.sv
design/backfill_job_scheduler.sv
tb/schedule_checker.sv
tb/testbench.sv
